// ===== hdl/pidc_pkg.sv =====
// ----------------------------------------------------------------------------
// pidc_pkg: shared types and arithmetic for the clamped PID controller
// Register indexes, sequencer states, command/status structs and the
// Q16.16 round, saturate and clamp helpers.
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned UregW = 31;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned ModeW = 2;

  // Register indexes
  localparam logic [IdxW-1:0] REG_SETPOINT  = 3'd0;
  localparam logic [IdxW-1:0] REG_GAIN_P    = 3'd1;
  localparam logic [IdxW-1:0] REG_GAIN_I    = 3'd2;
  localparam logic [IdxW-1:0] REG_GAIN_D    = 3'd3;
  localparam logic [IdxW-1:0] REG_STEP_TIME = 3'd4;
  localparam logic [IdxW-1:0] REG_STEP_RATE = 3'd5;
  localparam logic [IdxW-1:0] REG_INT_LIMIT = 3'd6;
  localparam logic [IdxW-1:0] REG_OUT_LIMIT = 3'd7;

  // Reset values
  localparam logic [UregW-1:0] STEP_TIME_RST = 31'd131;
  localparam logic [UregW-1:0] STEP_RATE_RST = 31'd32768000;
  localparam logic [UregW-1:0] INT_LIMIT_RST = 31'd327680000;

  // Input mode codes; the high bit alone selects a clear
  localparam logic [ModeW-1:0] MODE_MEAS  = 2'd0;
  localparam logic [ModeW-1:0] MODE_ERROR = 2'd1;
  localparam int unsigned      ModeClrBit = 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_DR,
    ST_MUL_IT,
    ST_MUL_DK,
    ST_ACC,
    ST_MUL_I,
    ST_TERM_I,
    ST_FIN
  } pidc_state_e;

  typedef enum logic [2:0] {
    MUL_P,   // gain_p * error
    MUL_DR,  // error delta * step_rate
    MUL_IT,  // error * step_time
    MUL_DK,  // gain_d * scaled delta
    MUL_IK   // gain_i * integral
  } pidc_mul_e;

  typedef struct packed {
    logic      capture;
    logic      clear;
    logic      mul_en;
    pidc_mul_e mul_sel;
    logic      ld_diff;
    logic      ld_p;
    logic      ld_d1;
    logic      ld_inc;
    logic      ld_d;
    logic      ld_acc;
    logic      ld_i;
    logic      ld_out;
  } pidc_cmd_t;

  typedef struct packed {
    logic clear_req;
  } pidc_status_t;

  function automatic logic signed [DataW-1:0] sat48(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sh0000_7FFF_FFFF;
    lo = -48'sh0000_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[DataW-1:0];
  endfunction

  // Round a Q32.32 product to Q16.16, half up, then saturate
  function automatic logic signed [DataW-1:0] round_q16(input logic signed [63:0] prod);
    logic signed [63:0] t;
    t = prod + 64'sd32768;
    return sat48(t[63:16]);
  endfunction

  function automatic logic signed [DataW-1:0] sat_sum(input logic signed [33:0] v);
    return sat48({{14{v[33]}}, v});
  endfunction

  // Symmetric magnitude clamp; a zero limit passes the value through
  function automatic logic signed [DataW-1:0] clamp_mag(input logic signed [DataW-1:0] v,
                                                        input logic [UregW-1:0] lim);
    logic signed [DataW-1:0] l;
    l = signed'({1'b0, lim});
    if (lim == '0) begin
      return v;
    end else if (v > l) begin
      return l;
    end else if (v < -l) begin
      return -l;
    end
    return v;
  endfunction

endpackage

// ===== hdl/pidc_if.sv =====
// ----------------------------------------------------------------------------
// pidc_if: stream channels of the clamped PID controller
// Input channel carries mode and value; output channel carries the drive and the terms.
// ----------------------------------------------------------------------------
interface pidc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface pidc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic signed [31:0] p_term;
  logic signed [31:0] i_term;
  logic signed [31:0] d_term;

  modport source (output valid, output drive, output p_term, output i_term,
                  output d_term, input ready);
  modport sink   (input valid, input drive, input p_term, input i_term,
                  input d_term, output ready);
endinterface

// ===== hdl/pid_controller_clamped.sv =====
// ----------------------------------------------------------------------------
// pid_controller_clamped: discrete PID step in signed Q16.16
// One update or clear per input transfer, with integral and output magnitude clamps,
// built as a sequencer driving a datapath with one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                              | handshake
//  ---------+-----+--------------------------------------+----------------
//  in_if    | in  | mode[1:0], value[31:0]               | valid / ready
//  out_if   | out | drive, p_term, i_term, d_term [31:0] | valid / ready
//  cfg      | in  | cfg_idx_i[2:0], cfg_data_i[31:0]     | cfg_we_i only
//
//  The error is captured with the input transfer, then five products go
//  through the single 32x32 multiplier, each rounded and saturated from
//  the product register, with the integral update before the last product
//  and the final sum into the output register after it. A clear request
//  goes from the first step straight to the final one. Input ready is high
//  only while idle, so no new input is taken until an update or clear is
//  through; a result waiting on out_if does not stop the next update,
//  which holds in its final step until the output register is free.
//  Reset clears the kept error and integral and loads register defaults.
// ----------------------------------------------------------------------------
module pid_controller_clamped (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  pidc_in_if.sink                    in_if,
  pidc_out_if.source                 out_if,
  input  logic                       cfg_we_i,
  input  logic [pidc_pkg::IdxW-1:0]  cfg_idx_i,
  input  logic [pidc_pkg::DataW-1:0] cfg_data_i
);
  import pidc_pkg::*;

  pidc_cmd_t    cmd;
  pidc_status_t status;

  // Sequencer: owns the handshakes and steps the datapath
  pidc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: registers, shared multiplier, state and output register
  pidc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_mode_i  (in_if.mode),
    .in_value_i (in_if.value),
    .cmd_i      (cmd),
    .status_o   (status),
    .drive_o    (out_if.drive),
    .p_term_o   (out_if.p_term),
    .i_term_o   (out_if.i_term),
    .d_term_o   (out_if.d_term)
  );

endmodule

// ===== hdl/pidc_dp.sv =====
// ----------------------------------------------------------------------------
// pidc_dp: datapath of the clamped PID controller
// Configuration registers, kept state, one shared 32x32 multiplier with a
// product register, and the output register.
// ----------------------------------------------------------------------------
module pidc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pidc_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [pidc_pkg::DataW-1:0]    cfg_data_i,
  input  logic [pidc_pkg::ModeW-1:0]    in_mode_i,
  input  logic signed [pidc_pkg::DataW-1:0] in_value_i,
  input  pidc_pkg::pidc_cmd_t           cmd_i,
  output pidc_pkg::pidc_status_t        status_o,
  output logic signed [pidc_pkg::DataW-1:0] drive_o,
  output logic signed [pidc_pkg::DataW-1:0] p_term_o,
  output logic signed [pidc_pkg::DataW-1:0] i_term_o,
  output logic signed [pidc_pkg::DataW-1:0] d_term_o
);
  import pidc_pkg::*;

  logic signed [DataW-1:0] setpoint_q, gain_p_q, gain_i_q, gain_d_q;
  logic [UregW-1:0]        step_time_q, step_rate_q, int_limit_q, out_limit_q;

  logic signed [DataW-1:0] err_q, diff_q, last_q, acc_q;
  logic signed [DataW-1:0] p_q, d1_q, inc_q, d_q, i_q;
  logic signed [63:0]      prod_q;
  logic                    clear_q;
  logic signed [DataW-1:0] drive_q, p_out_q, i_out_q, d_out_q;

  logic signed [DataW-1:0] mul_a, mul_b, rnd, err_d, sum;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q  <= '0;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      step_time_q <= STEP_TIME_RST;
      step_rate_q <= STEP_RATE_RST;
      int_limit_q <= INT_LIMIT_RST;
      out_limit_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SETPOINT:  setpoint_q  <= cfg_data_i;
        REG_GAIN_P:    gain_p_q    <= cfg_data_i;
        REG_GAIN_I:    gain_i_q    <= cfg_data_i;
        REG_GAIN_D:    gain_d_q    <= cfg_data_i;
        REG_STEP_TIME: step_time_q <= cfg_data_i[UregW-1:0];
        REG_STEP_RATE: step_rate_q <= cfg_data_i[UregW-1:0];
        REG_INT_LIMIT: int_limit_q <= cfg_data_i[UregW-1:0];
        REG_OUT_LIMIT: out_limit_q <= cfg_data_i[UregW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_P:   begin mul_a = gain_p_q; mul_b = err_q;                       end
      MUL_DR:  begin mul_a = diff_q;   mul_b = signed'({1'b0, step_rate_q}); end
      MUL_IT:  begin mul_a = err_q;    mul_b = signed'({1'b0, step_time_q}); end
      MUL_DK:  begin mul_a = gain_d_q; mul_b = d1_q;                        end
      MUL_IK:  begin mul_a = gain_i_q; mul_b = acc_q;                       end
      default: begin mul_a = '0;       mul_b = '0;                          end
    endcase
  end

  assign rnd = round_q16(prod_q);

  assign err_d = (in_mode_i == MODE_MEAS)
               ? sat_sum(34'(setpoint_q) - 34'(in_value_i))
               : in_value_i;

  assign sum = clamp_mag(sat_sum(34'(p_q) + 34'(i_q) + 34'(d_q)), out_limit_q);

  // Kept state: previous error and integral
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      acc_q  <= '0;
    end else if (cmd_i.clear) begin
      last_q <= '0;
      acc_q  <= '0;
    end else if (cmd_i.ld_acc) begin
      last_q <= err_q;
      acc_q  <= clamp_mag(sat_sum(34'(acc_q) + 34'(inc_q)), int_limit_q);
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      err_q   <= err_d;
      clear_q <= in_mode_i[ModeClrBit];
    end
    if (cmd_i.mul_en)  prod_q <= mul_a * mul_b;
    if (cmd_i.ld_diff) diff_q <= sat_sum(34'(err_q) - 34'(last_q));
    if (cmd_i.clear) begin
      p_q <= '0;
      i_q <= '0;
      d_q <= '0;
    end else begin
      if (cmd_i.ld_p) p_q <= rnd;
      if (cmd_i.ld_d) d_q <= rnd;
      if (cmd_i.ld_i) i_q <= rnd;
    end
    if (cmd_i.ld_d1)  d1_q  <= rnd;
    if (cmd_i.ld_inc) inc_q <= rnd;
    if (cmd_i.ld_out) begin
      drive_q <= sum;
      p_out_q <= p_q;
      i_out_q <= i_q;
      d_out_q <= d_q;
    end
  end

  assign status_o.clear_req = clear_q;
  assign drive_o  = drive_q;
  assign p_term_o = p_out_q;
  assign i_term_o = i_out_q;
  assign d_term_o = d_out_q;

endmodule

// ===== hdl/pidc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pidc_ctrl: sequencer of the clamped PID controller
// Steps the shared multiplier through the five products of one update and
// owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module pidc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  pidc_pkg::pidc_status_t status_i,
  output pidc_pkg::pidc_cmd_t    cmd_o
);
  import pidc_pkg::*;

  pidc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        in_fire, out_free;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_MUL_P;
      ST_MUL_P:  state_d = status_i.clear_req ? ST_FIN : ST_MUL_DR;
      ST_MUL_DR: state_d = ST_MUL_IT;
      ST_MUL_IT: state_d = ST_MUL_DK;
      ST_MUL_DK: state_d = ST_ACC;
      ST_ACC:    state_d = ST_MUL_I;
      ST_MUL_I:  state_d = ST_TERM_I;
      ST_TERM_I: state_d = ST_FIN;
      ST_FIN:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.mul_sel = MUL_P;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_MUL_P: begin
        cmd_o.clear   = status_i.clear_req;
        cmd_o.mul_en  = !status_i.clear_req;
        cmd_o.ld_diff = 1'b1;
      end
      ST_MUL_DR: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DR;
        cmd_o.ld_p    = 1'b1;
      end
      ST_MUL_IT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_IT;
        cmd_o.ld_d1   = 1'b1;
      end
      ST_MUL_DK: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DK;
        cmd_o.ld_inc  = 1'b1;
      end
      ST_ACC: begin
        cmd_o.ld_d    = 1'b1;
        cmd_o.ld_acc  = 1'b1;
      end
      ST_MUL_I: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_IK;
      end
      ST_TERM_I: cmd_o.ld_i = 1'b1;
      ST_FIN:    cmd_o.ld_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.ld_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != ST_IDLE)
    else $error("sequencer stayed idle after an input transfer");

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten before its transfer");

  a_result_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && state_d == ST_IDLE) |=> out_valid_q)
    else $error("update finished without a pending result");

  a_single_mul_user: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_en |-> state_q != ST_IDLE && state_q != ST_FIN)
    else $error("multiplier started outside an update");

endmodule
